### hdl/tssg_pkg.sv
// Shared types and constants of the triangle sweep setpoint generator.
package tssg_pkg;

	localparam int MM_TO_UM      = 1000;
	localparam int POS_SCALE     = 39;
	localparam int FORCE_SCALE   = 20;
	localparam int SERVO_BASE    = 1200;
	localparam int SERVO_OFFSET  = 20000;
	localparam int SERVO_DIV     = 17;
	localparam int STEP_FALLBACK = 10;
	localparam int TARGET_LIMIT  = 20;

	// serial divider: quotient and dividend width, divisor width
	localparam int DIV_BITS  = 17;
	localparam int DSR_BITS  = 16;
	localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

	// configuration register indexes
	localparam logic [1:0] REG_FIRST_TARGET  = 2'd0;
	localparam logic [1:0] REG_SECOND_TARGET = 2'd1;
	localparam logic [1:0] REG_STEP_DIVISOR  = 2'd2;

	// sweep segments
	localparam logic [1:0] SEG_TO_FIRST  = 2'd0;
	localparam logic [1:0] SEG_TO_SECOND = 2'd1;
	localparam logic [1:0] SEG_BACK      = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_MOVE,
		ST_SERVO,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

### hdl/tssg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module tssg_div
	import tssg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [DSR_BITS-1:0] divisor,
	output logic [DIV_BITS-1:0] quotient,
	output div_status_t         status
);

	logic [DIV_BITS-1:0]  dvd_q;
	logic [DIV_BITS-1:0]  rem_q;
	logic [DSR_BITS-1:0]  dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_BITS-1:0]  rem_sh;
	logic [DIV_BITS:0]    diff;
	logic                 ge;

	// remainder stays below the divisor, so its top bit is always clear
	assign rem_sh = {rem_q[DIV_BITS-2:0], dvd_q[DIV_BITS-1]};
	assign diff   = {1'b0, rem_sh} - {{(DIV_BITS + 1 - DSR_BITS){1'b0}}, dsr_q};
	assign ge     = ~diff[DIV_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_BITS-1:0] : rem_sh;
			dvd_q <= {dvd_q[DIV_BITS-2:0], ge};
		end
	end

	assign quotient    = dvd_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

### hdl/triangle_sweep_setpoint_generator.sv
// Top level of the triangle sweep setpoint generator.
//
// Usage: write first_target_mm, second_target_mm and step_divisor through the
// cfg_write/cfg_index/cfg_data port while the block is idle. Items enter on
// in_valid/in_ready; action 0 starts a sweep, action 1 reports the two ADC
// samples of the current point and advances. Every item gives one result
// item on out_valid/out_ready: scaled samples, next point in um, its servo
// compare value and a done mark.
//
// Sequence: one item at a time. A start item runs the division of travel by
// divisor in the shared bit-serial divider, then, if a point is found, the
// division of point plus 20000 by 17. A report item runs that point division
// only; a report with no point left skips the divider. in_ready is high only
// in the idle state.
//
// Output: the result register holds its item until out_ready; the next input
// item is taken meanwhile and its result waits in the push state.
// Reset: step is 10, no sweep running, registers 0 0 1, output empty.
module triangle_sweep_setpoint_generator
	import tssg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [9:0]         adc_position,
	input  logic [9:0]         adc_force,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] measured_position,
	output logic signed [14:0] measured_force,
	output logic signed [15:0] next_point_um,
	output logic [11:0]        servo_compare,
	output logic               sweep_done
);

	// configuration registers
	logic signed [5:0]    first_mm_q;
	logic signed [5:0]    second_mm_q;
	logic [15:0]          divisor_q;

	// sweep state
	state_t               state_q, state_d;
	logic [DIV_BITS-1:0]  step_q;
	logic signed [15:0]   point_q;
	logic [1:0]           segment_q;
	logic                 running_q;

	// item in flight
	logic                 act_q;
	logic signed [15:0]   mpos_q;
	logic signed [14:0]   mfrc_q;
	logic                 have_q;
	logic [11:0]          servo_q;

	// result register
	logic                 out_valid_q;
	logic signed [15:0]   out_mpos_q;
	logic signed [14:0]   out_mfrc_q;
	logic signed [15:0]   out_point_q;
	logic [11:0]          out_servo_q;
	logic                 out_done_q;

	// divider hookup
	logic                 div_start;
	logic [DIV_BITS-1:0]  div_dividend;
	logic [DSR_BITS-1:0]  div_divisor;
	logic [DIV_BITS-1:0]  div_quot;
	div_status_t          div_stat;

	// strobes from the sequencer
	logic                 take_in;
	logic                 load_step;
	logic                 load_move;
	logic                 load_servo;
	logic                 load_out;

	function automatic logic signed [15:0] target_um(input logic signed [5:0] mm);
		logic signed [5:0] c;
		c = mm;
		if (mm < -6'sd20) c = -6'sd20;
		if (mm > 6'sd20)  c = 6'sd20;
		return 16'(32'(c) * MM_TO_UM);
	endfunction

	logic signed [15:0] l1, l2;
	assign l1 = target_um(first_mm_q);
	assign l2 = target_um(second_mm_q);

	// travel = |L1| + 2|L2-L1|, at most 100000
	logic signed [17:0] l1_x, diff_x, abs_l1, abs_d, travel_x;
	assign l1_x     = 18'(l1);
	assign diff_x   = 18'(l2) - 18'(l1);
	assign abs_l1   = l1_x[17] ? -l1_x : l1_x;
	assign abs_d    = diff_x[17] ? -diff_x : diff_x;
	assign travel_x = abs_l1 + (abs_d <<< 1);

	// segment selection: enter from the first segment, or the one after the current
	logic               l1_nz, l12_ne;
	assign l1_nz  = (l1 != 16'sd0);
	assign l12_ne = (l1 != l2);

	logic               ent_have;
	logic [1:0]         ent_seg;
	logic signed [15:0] ent_point;
	logic [1:0]         ent_from;

	assign ent_from = act_q ? (segment_q + 2'd1) : SEG_TO_FIRST;

	always_comb begin
		ent_have  = 1'b0;
		ent_seg   = SEG_TO_FIRST;
		ent_point = 16'sd0;
		case (ent_from)
			SEG_TO_FIRST: begin
				if (l1_nz) begin
					ent_have = 1'b1;
				end else if (l12_ne) begin
					ent_have  = 1'b1;
					ent_seg   = SEG_TO_SECOND;
					ent_point = l1;
				end
			end
			SEG_TO_SECOND: begin
				if (l12_ne) begin
					ent_have  = 1'b1;
					ent_seg   = SEG_TO_SECOND;
					ent_point = l1;
				end
			end
			SEG_BACK: begin
				if (l12_ne) begin
					ent_have  = 1'b1;
					ent_seg   = SEG_BACK;
					ent_point = l2;
				end
			end
			default: ent_have = 1'b0;
		endcase
	end

	// step along the current segment
	logic signed [18:0] p_x, e_x, up_x, dn_x, st_x;
	logic signed [15:0] seg_end;
	logic               go_up, go_dn;

	assign seg_end = (segment_q == SEG_TO_SECOND) ? l2 : l1;
	assign p_x     = 19'(point_q);
	assign e_x     = 19'(seg_end);
	assign st_x    = {2'b00, step_q};
	assign up_x    = p_x + st_x;
	assign dn_x    = p_x - st_x;
	assign go_up   = (p_x < e_x) && (up_x < e_x);
	assign go_dn   = (p_x > e_x) && (dn_x > e_x);

	logic               mv_have;
	logic [1:0]         mv_seg;
	logic signed [15:0] mv_point;

	always_comb begin
		mv_have  = 1'b0;
		mv_seg   = SEG_TO_FIRST;
		mv_point = 16'sd0;
		if (!act_q) begin
			mv_have  = ent_have;
			mv_seg   = ent_seg;
			mv_point = ent_point;
		end else if (running_q) begin
			if (go_up) begin
				mv_have  = 1'b1;
				mv_seg   = segment_q;
				mv_point = up_x[15:0];
			end else if (go_dn) begin
				mv_have  = 1'b1;
				mv_seg   = segment_q;
				mv_point = dn_x[15:0];
			end else begin
				mv_have  = ent_have;
				mv_seg   = ent_seg;
				mv_point = ent_point;
			end
		end
		if (!mv_have) begin
			mv_seg   = SEG_TO_FIRST;
			mv_point = 16'sd0;
		end
	end

	// ADC scaling: sample minus midscale is the sample with its top bit flipped
	logic signed [9:0] pos_c, frc_c;
	assign pos_c = {~adc_position[9], adc_position[8:0]};
	assign frc_c = {~adc_force[9], adc_force[8:0]};

	// servo dividend p + 20000, 0..40000
	logic signed [16:0] servo_sum;
	assign servo_sum = 17'(mv_point) + 17'(SERVO_OFFSET);

	// divider operand mux: travel at start, servo point otherwise
	always_comb begin
		if (state_q == ST_IDLE) begin
			div_dividend = travel_x[DIV_BITS-1:0];
			div_divisor  = (divisor_q == 16'd0) ? 16'd1 : divisor_q;
		end else begin
			div_dividend = {1'b0, servo_sum[15:0]};
			div_divisor  = DSR_BITS'(SERVO_DIV);
		end
	end

	tssg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.status   (div_stat)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		take_in    = 1'b0;
		load_step  = 1'b0;
		load_move  = 1'b0;
		load_servo = 1'b0;
		load_out   = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					take_in   = 1'b1;
					div_start = ~action;
					state_d   = action ? ST_MOVE : ST_STEP;
				end
			end
			ST_STEP: begin
				if (div_stat.done) begin
					load_step = 1'b1;
					state_d   = ST_MOVE;
				end
			end
			ST_MOVE: begin
				load_move = 1'b1;
				div_start = mv_have;
				state_d   = mv_have ? ST_SERVO : ST_PUSH;
			end
			ST_SERVO: begin
				if (div_stat.done) begin
					load_servo = 1'b1;
					state_d    = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// configuration and sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_mm_q  <= '0;
			second_mm_q <= '0;
			divisor_q   <= 16'd1;
			step_q      <= DIV_BITS'(STEP_FALLBACK);
			point_q     <= '0;
			segment_q   <= SEG_TO_FIRST;
			running_q   <= 1'b0;
			have_q      <= 1'b0;
			act_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_FIRST_TARGET:  first_mm_q  <= cfg_data[5:0];
					REG_SECOND_TARGET: second_mm_q <= cfg_data[5:0];
					REG_STEP_DIVISOR:  divisor_q   <= cfg_data;
					default: ;
				endcase
			end
			if (take_in) act_q <= action;
			if (load_step) begin
				step_q <= (div_quot == '0) ? DIV_BITS'(STEP_FALLBACK) : div_quot;
			end
			if (load_move) begin
				point_q   <= mv_point;
				segment_q <= mv_seg;
				running_q <= mv_have;
				have_q    <= mv_have;
			end
			if (load_out)      out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			mpos_q <= action ? 16'(32'(pos_c) * POS_SCALE) : 16'sd0;
			mfrc_q <= action ? 15'(32'(frc_c) * FORCE_SCALE) : 15'sd0;
		end
		if (load_move)  servo_q <= 12'd0;
		if (load_servo) servo_q <= 12'(SERVO_BASE) + div_quot[11:0];
		if (load_out) begin
			out_mpos_q  <= mpos_q;
			out_mfrc_q  <= mfrc_q;
			out_point_q <= have_q ? point_q : 16'sd0;
			out_servo_q <= have_q ? servo_q : 12'd0;
			out_done_q  <= ~have_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign measured_position = out_mpos_q;
	assign measured_force    = out_mfrc_q;
	assign next_point_um     = out_point_q;
	assign servo_compare     = out_servo_q;
	assign sweep_done        = out_done_q;

endmodule

### sim/tb_triangle_sweep_setpoint_generator.sv
// Self-checking testbench for the triangle sweep setpoint generator.
module tb_triangle_sweep_setpoint_generator;
	import tssg_pkg::*;

	// Item codes on the action field
	localparam logic ACT_START  = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	localparam int ADC_MID       = 512;
	localparam int IDLE_PCT      = 10;      // percent of cycles each side idles
	localparam int RANDOM_ITEMS  = 1830;    // random items after the directed part
	localparam int STEADY_PHASE  = 4;       // random phase run with no idling at all
	localparam int SETTLE_CYCLES = 60;      // wait after the last result before the final check
	localparam int CYCLE_LIMIT   = 800000;
	localparam int PRINT_LIMIT   = 40;

	typedef struct packed {
		logic       action;
		logic [9:0] adc_position;
		logic [9:0] adc_force;
	} sweep_cmd_t;

	typedef struct packed {
		logic signed [15:0] pos;
		logic signed [14:0] frc;
		logic signed [15:0] point;
		logic [11:0]        servo;
		logic               done;
	} sweep_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = REG_FIRST_TARGET;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = ACT_START;
	logic [9:0]         adc_position = '0;
	logic [9:0]         adc_force = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] measured_position;
	logic signed [14:0] measured_force;
	logic signed [15:0] next_point_um;
	logic [11:0]        servo_compare;
	logic               sweep_done;

	triangle_sweep_setpoint_generator DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.adc_position      (adc_position),
		.adc_force         (adc_force),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.measured_position (measured_position),
		.measured_force    (measured_force),
		.next_point_um     (next_point_um),
		.servo_compare     (servo_compare),
		.sweep_done        (sweep_done)
	);

	// Items waiting to be driven, and results owed by the block, oldest first
	sweep_cmd_t    cmd_queue[$];
	sweep_result_t pending_results[$];
	sweep_cmd_t    drive_cmd;

	// When set, neither side idles
	bit steady = 1'b0;

	int error_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int sweep_starts = 0;
	int done_marks = 0;
	int reg_writes = 0;
	int cycle_count = 0;

	// Sweep predictor: register copies and sweep state, kept in step with the block.
	// Targets are held as the 6-bit signed register value; saturation happens on use.
	int  l1_mm = 0;
	int  l2_mm = 0;
	int  divisor = 1;
	int  pred_step = STEP_FALLBACK;
	int  pred_point = 0;
	int  pred_seg = SEG_TO_FIRST;
	bit  pred_running = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still owed", cycle_count,
				pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(string what, int got, int want);
		if (error_count < PRINT_LIMIT)
			$display("MISMATCH at cycle %0d, result %0d: %s got %0d expected %0d",
				cycle_count, results_checked, what, got, want);
		error_count++;
	endtask

	// Target in micrometres, saturated to the legal travel
	function automatic int target_um(int mm);
		if (mm < -TARGET_LIMIT)
			mm = -TARGET_LIMIT;
		if (mm > TARGET_LIMIT)
			mm = TARGET_LIMIT;
		return mm * MM_TO_UM;
	endfunction

	function automatic int seg_origin(int s);
		if (s == SEG_TO_FIRST)
			return 0;
		if (s == SEG_TO_SECOND)
			return target_um(l1_mm);
		return target_um(l2_mm);
	endfunction

	function automatic int seg_goal(int s);
		if (s == SEG_TO_SECOND)
			return target_um(l2_mm);
		return target_um(l1_mm);
	endfunction

	// Move into the first non-empty segment from s on; 0 when the sweep is over
	function automatic bit enter_segment(int s);
		while (s <= SEG_BACK) begin
			if (seg_origin(s) != seg_goal(s)) begin
				pred_seg = s;
				pred_point = seg_origin(s);
				return 1'b1;
			end
			s++;
		end
		return 1'b0;
	endfunction

	// One step toward the segment end; the end point itself is never visited
	function automatic bit advance_point();
		int e;
		int p;
		e = seg_goal(pred_seg);
		p = pred_point;
		if (p < e && p + pred_step < e) begin
			pred_point = p + pred_step;
			return 1'b1;
		end
		if (p > e && p - pred_step > e) begin
			pred_point = p - pred_step;
			return 1'b1;
		end
		return enter_segment(pred_seg + 1);
	endfunction

	function automatic sweep_result_t predict_result(sweep_cmd_t c);
		sweep_result_t r;
		bit have;
		int p1;
		int p2;
		int travel;
		r = '0;
		if (c.action == ACT_START) begin
			p1 = target_um(l1_mm);
			p2 = target_um(l2_mm);
			travel = (p1 < 0 ? -p1 : p1) + 2 * (p2 < p1 ? p1 - p2 : p2 - p1);
			pred_step = travel / (divisor == 0 ? 1 : divisor);
			if (pred_step == 0)
				pred_step = STEP_FALLBACK;
			have = enter_segment(SEG_TO_FIRST);
			pred_running = have;
			sweep_starts++;
		end else begin
			r.pos = 16'((int'(c.adc_position) - ADC_MID) * POS_SCALE);
			r.frc = 15'((int'(c.adc_force) - ADC_MID) * FORCE_SCALE);
			// a report with no sweep running only scales the samples
			have = 1'b0;
			if (pred_running) begin
				have = advance_point();
				pred_running = have;
			end
		end
		if (have) begin
			r.point = 16'(pred_point);
			r.servo = 12'(SERVO_BASE + (pred_point + SERVO_OFFSET) / SERVO_DIV);
			r.done = 1'b0;
		end else begin
			pred_point = 0;
			pred_seg = SEG_TO_FIRST;
			r.done = 1'b1;
		end
		return r;
	endfunction

	// Driver: the expectation is formed at the edge where the item is taken,
	// then the next item (or a gap) is put on the bus
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			pending_results.push_back(predict_result(drive_cmd));
			items_sent++;
		end
		if (!in_valid || in_ready) begin
			if (cmd_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				drive_cmd = cmd_queue.pop_front();
				in_valid <= 1'b1;
				action <= drive_cmd.action;
				adc_position <= drive_cmd.adc_position;
				adc_force <= drive_cmd.adc_force;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: every taken result is checked field by field against the oldest expectation
	always @(posedge clk) begin
		sweep_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing owed, next_point_um", next_point_um, 0);
			end else begin
				want = pending_results.pop_front();
				if (measured_position !== want.pos)
					report_mismatch("measured_position", measured_position, $signed(want.pos));
				if (measured_force !== want.frc)
					report_mismatch("measured_force", measured_force, $signed(want.frc));
				if (next_point_um !== want.point)
					report_mismatch("next_point_um", next_point_um, $signed(want.point));
				if (servo_compare !== want.servo)
					report_mismatch("servo_compare", servo_compare, want.servo);
				if (sweep_done !== want.done)
					report_mismatch("sweep_done", sweep_done, want.done);
				if (want.done)
					done_marks++;
			end
			results_checked++;
		end
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic void queue_cmd(logic act, int pos, int frc);
		sweep_cmd_t c;
		c.action = act;
		c.adc_position = 10'(pos);
		c.adc_force = 10'(frc);
		cmd_queue.push_back(c);
	endfunction

	// ADC samples lean on the rails now and then
	function automatic int rand_adc();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return 0;
		if (roll < 10)
			return 1023;
		return $urandom_range(1023);
	endfunction

	// Register write while the block sits idle; the predictor copy follows at once
	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_FIRST_TARGET: l1_mm = $signed(data[5:0]);
			REG_SECOND_TARGET: l2_mm = $signed(data[5:0]);
			default: divisor = int'(data);
		endcase
		reg_writes++;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Hold off until every item has gone in and every owed result has come back
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || in_valid || pending_results.size() != 0);
	endtask

	// Target value in the low six bits, junk above that the block must ignore
	function automatic logic [15:0] rand_target();
		logic [5:0] mm;
		if ($urandom_range(99) < 85)
			mm = 6'($urandom_range(2 * TARGET_LIMIT) - TARGET_LIMIT);
		else
			mm = 6'($urandom_range(63));
		return {10'($urandom_range(1023)), mm};
	endfunction

	function automatic logic [15:0] rand_divisor();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return 16'($urandom_range(40, 1));
		if (roll < 78)
			return 16'd0;
		if (roll < 84)
			return 16'd1;
		if (roll < 90)
			return 16'hFFFF;
		return 16'($urandom_range(65535));
	endfunction

	// Mostly well-formed sweeps (start, then reports that often run past the end),
	// plus some stray items. A few leading reports continue a sweep left running.
	function automatic int queue_sweeps(int target);
		int n;
		int k;
		n = 0;
		repeat ($urandom_range(4)) begin
			queue_cmd(ACT_REPORT, rand_adc(), rand_adc());
			n++;
		end
		while (n < target) begin
			if ($urandom_range(99) < 85) begin
				queue_cmd(ACT_START, rand_adc(), rand_adc());
				n++;
				k = $urandom_range(50, 1);
				repeat (k) begin
					queue_cmd(ACT_REPORT, rand_adc(), rand_adc());
					n++;
				end
			end else begin
				queue_cmd(1'($urandom_range(1)), rand_adc(), rand_adc());
				n++;
			end
		end
		return n;
	endfunction

	initial begin
		int queued;
		int phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: all segments empty, so a start finds no point; reports
		// outside a sweep still scale the samples at both rails and mid scale
		queue_cmd(ACT_REPORT, 0, 1023);
		queue_cmd(ACT_START, 1023, 0);
		queue_cmd(ACT_REPORT, 1023, 0);
		queue_cmd(ACT_REPORT, ADC_MID, ADC_MID);
		wait_quiet();

		// Targets beyond the range saturate to -20/+20 mm, zero divisor acts as one:
		// the step covers the whole travel and each segment gives a single point
		write_reg(REG_FIRST_TARGET, 16'hFFE0);
		write_reg(REG_SECOND_TARGET, 16'h001F);
		write_reg(REG_STEP_DIVISOR, 16'h0000);
		queue_cmd(ACT_START, 1, 1022);
		repeat (4) queue_cmd(ACT_REPORT, 1022, 1);
		wait_quiet();

		// Equal targets: the second and third segments are empty and skipped
		write_reg(REG_FIRST_TARGET, 16'h0005);
		write_reg(REG_SECOND_TARGET, 16'h0005);
		write_reg(REG_STEP_DIVISOR, 16'h0003);
		queue_cmd(ACT_START, 0, 0);
		repeat (5) queue_cmd(ACT_REPORT, 511, 513);
		wait_quiet();

		// Huge divisor gives a zero step and the fallback of ten; a second start
		// restarts mid-sweep, and the sweep is left running into the next phase
		write_reg(REG_FIRST_TARGET, 16'h0000);
		write_reg(REG_SECOND_TARGET, 16'hAA39);
		write_reg(REG_STEP_DIVISOR, 16'hFFFF);
		queue_cmd(ACT_START, 1023, 1023);
		queue_cmd(ACT_REPORT, 0, 0);
		queue_cmd(ACT_REPORT, 1023, 1023);
		queue_cmd(ACT_START, 0, 1023);
		queue_cmd(ACT_REPORT, 1023, 0);

		// Random phases; register changes land between items of a running sweep,
		// and each phase waits until every owed result is back
		queued = 0;
		phase = 0;
		while (queued < RANDOM_ITEMS) begin
			wait_quiet();
			steady = (phase == STEADY_PHASE);
			if ($urandom_range(99) < 70)
				write_reg(REG_FIRST_TARGET, rand_target());
			if ($urandom_range(99) < 70)
				write_reg(REG_SECOND_TARGET, rand_target());
			if ($urandom_range(99) < 70)
				write_reg(REG_STEP_DIVISOR, rand_divisor());
			queued += queue_sweeps($urandom_range(120, 60));
			phase++;
		end

		wait_quiet();
		steady = 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 0, pending_results.size());

		$display("Sent %0d items over %0d random phases: %0d sweep starts, %0d done marks",
			items_sent, phase, sweep_starts, done_marks);
		$display("Checked %0d results across %0d register writes, %0d mismatches",
			results_checked, reg_writes, error_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/tssg_pkg.sv
hdl/tssg_div.sv
hdl/triangle_sweep_setpoint_generator.sv
sim/tb_triangle_sweep_setpoint_generator.sv
